// ===== rtl/core/ir_wall_distance_edge_detector_assert.svh =====
// ---------------------------------------------------------------------------
// IR wall distance edge detector assertion macros
// Assertion helpers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef IR_WALL_DISTANCE_EDGE_DETECTOR_ASSERT_SVH
`define IR_WALL_DISTANCE_EDGE_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define IWD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IWD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IWD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/iwd_pkg.sv =====
// ---------------------------------------------------------------------------
// IR wall distance package
// Shared constants and types for the distance lanes and the merge stage.
// ---------------------------------------------------------------------------
package iwd_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int FRAC_BITS    = 8;
    localparam int DIST_W       = 16;
    localparam int DEV_W        = 17;
    localparam int SCALE_W      = 20;
    localparam int OFFSET_W     = 18;
    localparam int NUM_CH       = 4;

    localparam int MIN_ADC      = 20;
    localparam logic [DIST_W-1:0] MAXD    = DIST_W'(135 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_15   = DIST_W'(15 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_30   = DIST_W'(30 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_42   = DIST_W'(42 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_60   = DIST_W'(60 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_65   = DIST_W'(65 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_70   = DIST_W'(70 << FRAC_BITS);
    localparam logic [DIST_W-1:0] MM_130  = DIST_W'(130 << FRAC_BITS);
    localparam logic [31:0]       LN2_Q32 = 32'd2977044472;
    localparam logic [32:0]       EDGE_TRAVEL = 33'd720;
    localparam int JITTER_CUT   = 3;

    // Register indexes.
    localparam logic [2:0] REG_SCALE_FL  = 3'd0;
    localparam logic [2:0] REG_SCALE_L   = 3'd1;
    localparam logic [2:0] REG_SCALE_R   = 3'd2;
    localparam logic [2:0] REG_SCALE_FR  = 3'd3;
    localparam logic [2:0] REG_OFFSET_FL = 3'd4;
    localparam logic [2:0] REG_OFFSET_L  = 3'd5;
    localparam logic [2:0] REG_OFFSET_R  = 3'd6;
    localparam logic [2:0] REG_OFFSET_FR = 3'd7;

    localparam logic [SCALE_W-1:0]  SCALE_RST [NUM_CH] =
        '{20'd271360, 20'd218035, 20'd247117, 20'd319565};
    localparam logic [OFFSET_W-1:0] OFFSET_RST [NUM_CH] =
        '{18'd26598, 18'd21862, 18'd25421, 18'd32333};

    typedef struct packed {
        logic              busy;
        logic              far;
        logic [DIST_W-1:0] dist_q;
    } iwd_lane_res_t;

    typedef struct packed {
        logic                     edge_right;
        logic                     edge_left;
        logic [NUM_CH-1:0]        wall_mask;
        logic signed [DEV_W-1:0]  dev_fr;
        logic signed [DEV_W-1:0]  dev_r;
        logic signed [DEV_W-1:0]  dev_l;
        logic signed [DEV_W-1:0]  dev_fl;
        logic [DIST_W-1:0]        dist_fr;
        logic [DIST_W-1:0]        dist_r;
        logic [DIST_W-1:0]        dist_l;
        logic [DIST_W-1:0]        dist_fl;
    } iwd_result_t;

endpackage

// ===== rtl/core/iwd_lane.sv =====
// ---------------------------------------------------------------------------
// IR wall distance lane
// Turns one raw sample into a clamped distance, A / ln(x) - B.
// ---------------------------------------------------------------------------
module iwd_lane
    import iwd_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ADC_BITS-1:0]        sample,
    input  logic [SCALE_W-1:0]         scale,
    input  logic signed [OFFSET_W-1:0] offset,
    output iwd_lane_res_t              res
);

    localparam int NW  = $clog2(ADC_BITS);
    localparam int L2W = NW + 16;
    localparam int PW  = L2W + 32;
    localparam int DW  = PW - 36;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_SQ   = 3'd1;
    localparam logic [2:0] L_MUL  = 3'd2;
    localparam logic [2:0] L_LN   = 3'd3;
    localparam logic [2:0] L_DIV  = 3'd4;
    localparam logic [2:0] L_FIN  = 3'd5;
    localparam logic [2:0] L_LOW  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [30:0]       m_reg, m_next;
    logic [L2W-1:0]    l2_reg, l2_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [31:0]       quo_reg, quo_next;
    logic              busy_reg, busy_next;
    logic              far_reg, far_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic [NW-1:0]     msb;
    logic [4:0]        shamt;
    logic [30:0]       m_init;
    logic [61:0]       sq;
    logic [31:0]       msq;
    logic [PW-1:0]     prod_rnd;
    logic [DW-1:0]     ln;
    logic [DW:0]       trial;
    logic signed [33:0] diff;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < ADC_BITS; i++)
        begin
            if (sample[i])
            begin
                msb = NW'(i);
            end
        end
    end

    assign shamt    = 5'd30 - 5'(msb);
    assign m_init   = 31'(sample) << shamt;
    assign sq       = 62'(m_reg) * 62'(m_reg);
    assign msq      = sq[61:30];
    assign prod_rnd = prod_reg + (PW'(1) << 35);
    assign ln       = prod_rnd[PW-1:36];
    assign trial    = {rem_reg, quo_reg[31]};
    assign diff     = $signed({2'b00, quo_reg}) - 34'(offset);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        l2_next    = l2_reg;
        prod_next  = prod_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        busy_next  = busy_reg;
        far_next   = far_reg;
        dist_next  = dist_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    busy_next = 1'b1;
                    m_next    = m_init;
                    l2_next   = L2W'(msb);
                    cnt_next  = 6'd16;
                    if (sample <= ADC_BITS'(MIN_ADC))
                    begin
                        state_next = L_LOW;
                    end
                    else
                    begin
                        state_next = L_SQ;
                    end
                end
            end
            L_SQ:
            begin
                // One squaring of the mantissa yields one fraction bit of log2.
                if (msq[31])
                begin
                    m_next  = msq[31:1];
                    l2_next = {l2_reg[L2W-2:0], 1'b1};
                end
                else
                begin
                    m_next  = msq[30:0];
                    l2_next = {l2_reg[L2W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                prod_next  = PW'(l2_reg) * PW'(LN2_Q32);
                state_next = L_LN;
            end
            L_LN:
            begin
                div_next = ln;
                rem_next = '0;
                quo_next = {scale, 12'd0};
                cnt_next = 6'd32;
                if (ln == '0)
                begin
                    state_next = L_LOW;
                end
                else
                begin
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = DW'(trial - {1'b0, div_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:
            begin
                if (diff > $signed({18'd0, MAXD}))
                begin
                    far_next  = 1'b1;
                    dist_next = MAXD;
                end
                else if (diff < 34'sd0)
                begin
                    far_next  = 1'b0;
                    dist_next = '0;
                end
                else
                begin
                    far_next  = 1'b0;
                    dist_next = diff[DIST_W-1:0];
                end
                busy_next  = 1'b0;
                state_next = L_IDLE;
            end
            L_LOW:
            begin
                far_next   = 1'b0;
                dist_next  = MAXD;
                busy_next  = 1'b0;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        l2_reg   <= l2_next;
        prod_reg <= prod_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        far_reg  <= far_next;
        dist_reg <= dist_next;
    end

    assign res.busy   = busy_reg;
    assign res.far    = far_reg;
    assign res.dist_q = dist_reg;

endmodule

// ===== rtl/core/iwd_merge.sv =====
// ---------------------------------------------------------------------------
// IR wall distance merge stage
// Combines the four lane distances into deviations, wall bits and edges.
// ---------------------------------------------------------------------------
module iwd_merge
    import iwd_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                update,
    input  iwd_lane_res_t [NUM_CH-1:0]          lanes,
    input  logic [NUM_CH-1:0][ADC_BITS-1:0]     samples,
    input  logic signed [31:0]                  odometer,
    input  logic                                front_wall_mode,
    input  logic                                clear_min,
    input  logic                                clear_edge_pos,
    output iwd_result_t                         result
);

    logic [NUM_CH-1:0][ADC_BITS-1:0] prev_reg;
    logic [DIST_W-1:0]  min_l_reg, min_l_next, min_r_reg, min_r_next;
    logic signed [31:0] pos_l_reg, pos_l_next, pos_r_reg, pos_r_next;
    logic               edge_l, edge_r;
    logic               fronts_clear;

    function automatic logic edge_test(input logic [DIST_W-1:0] d,
                                       input logic [DIST_W-1:0] minv,
                                       input logic signed [31:0] pos,
                                       input logic signed [31:0] odo);
        logic signed [19:0] lhs;
        logic signed [32:0] trav;
        begin
            lhs  = $signed(20'(d) * 20'd3) - $signed(20'(minv) * 20'd5);
            trav = 33'(odo) - 33'(pos);
            edge_test = (lhs > $signed(20'(MM_15))) && (trav > $signed(EDGE_TRAVEL));
        end
    endfunction

    function automatic logic signed [DEV_W-1:0] sub_mm(input logic [DIST_W-1:0] d,
                                                       input logic [DIST_W-1:0] r);
        begin
            sub_mm = $signed({1'b0, d}) - $signed({1'b0, r});
        end
    endfunction

    function automatic logic quiet(input logic [ADC_BITS-1:0] a,
                                   input logic [ADC_BITS-1:0] b);
        logic [ADC_BITS-1:0] dd;
        begin
            dd    = (a > b) ? a - b : b - a;
            quiet = dd < ADC_BITS'(JITTER_CUT);
        end
    endfunction

    always_comb
    begin
        logic [DIST_W-1:0]  ml, mr;
        logic signed [31:0] pl, pr;
        ml = (clear_min || lanes[1].far) ? MAXD : min_l_reg;
        mr = (clear_min || lanes[2].far) ? MAXD : min_r_reg;
        pl = clear_edge_pos ? 32'sd0 : pos_l_reg;
        pr = clear_edge_pos ? 32'sd0 : pos_r_reg;
        edge_l = edge_test(lanes[1].dist_q, ml, pl, odometer);
        edge_r = edge_test(lanes[2].dist_q, mr, pr, odometer);
        if (edge_l)
        begin
            pos_l_next = odometer;
            min_l_next = MAXD;
        end
        else
        begin
            pos_l_next = pl;
            min_l_next = (lanes[1].dist_q < ml) ? lanes[1].dist_q : ml;
        end
        if (edge_r)
        begin
            pos_r_next = odometer;
            min_r_next = MAXD;
        end
        else
        begin
            pos_r_next = pr;
            min_r_next = (lanes[2].dist_q < mr) ? lanes[2].dist_q : mr;
        end
    end

    assign fronts_clear = (lanes[0].dist_q > MM_30) && (lanes[3].dist_q > MM_30);

    always_comb
    begin
        result.dist_fl = lanes[0].dist_q;
        result.dist_l  = lanes[1].dist_q;
        result.dist_r  = lanes[2].dist_q;
        result.dist_fr = lanes[3].dist_q;
        if (front_wall_mode)
        begin
            result.dev_fl = (lanes[0].dist_q < MM_60) ? sub_mm(lanes[0].dist_q, MM_42) : '0;
            result.dev_fr = (lanes[3].dist_q < MM_60) ? sub_mm(lanes[3].dist_q, MM_42) : '0;
        end
        else
        begin
            result.dev_fl = sub_mm(lanes[0].dist_q, MM_130);
            result.dev_fr = sub_mm(lanes[3].dist_q, MM_130);
        end
        result.dev_l = ((lanes[1].dist_q < MM_65) && quiet(samples[1], prev_reg[1])
                        && fronts_clear) ? sub_mm(lanes[1].dist_q, MM_42) : '0;
        result.dev_r = ((lanes[2].dist_q < MM_65) && quiet(samples[2], prev_reg[2])
                        && fronts_clear) ? sub_mm(lanes[2].dist_q, MM_42) : '0;
        result.wall_mask  = {lanes[3].dist_q < MM_130, lanes[2].dist_q < MM_70,
                             lanes[1].dist_q < MM_70, lanes[0].dist_q < MM_130};
        result.edge_left  = edge_l;
        result.edge_right = edge_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            min_l_reg <= MAXD;
            min_r_reg <= MAXD;
            pos_l_reg <= '0;
            pos_r_reg <= '0;
        end
        else if (update)
        begin
            prev_reg  <= samples;
            min_l_reg <= min_l_next;
            min_r_reg <= min_r_next;
            pos_l_reg <= pos_l_next;
            pos_r_reg <= pos_r_next;
        end
    end

endmodule

// ===== rtl/core/ir_wall_distance_edge_detector.sv =====
// ---------------------------------------------------------------------------
// IR wall distance edge detector
// Four-sensor IR distance estimator with side wall edge detection.
// ---------------------------------------------------------------------------
// Each request carries four raw IR samples, the odometer and three flags. Four
// identical lanes work on the samples side by side: each finds log2 of its
// sample by sixteen squarings of the normalised mantissa, one per cycle, turns
// it into ln with one multiply, then divides the calibration numerator by it in
// a restoring divider that gives one quotient bit per cycle. A sample of 20
// or less skips both the log loop and the divider, but the lanes are always
// awaited together. The merge stage then forms deviations, wall bits and the
// left and right edge flags, updates the side minima and edge positions, and
// loads the output register. One request is in flight at a time; the next is
// accepted while a finished result still waits in the output register.
// Configuration must be written only while the block is idle.
// ---------------------------------------------------------------------------
`include "ir_wall_distance_edge_detector_assert.svh"

module ir_wall_distance_edge_detector
    import iwd_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Input requests.
    input  logic                s_tvalid,
    output logic                s_tready,
    // From bit 0: adc_front_left, adc_left, adc_right, adc_front_right,
    // odometer, front_wall_mode, clear_min, clear_edge_pos, zero fill.
    input  logic [((4*ADC_BITS+35+7)/8)*8-1:0] s_tdata,
    // Results.
    output logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0: dist_front_left, dist_left, dist_right, dist_front_right,
    // dev_front_left, dev_left, dev_right, dev_front_right, wall_mask,
    // edge_left, edge_right, zero fill.
    output logic [143:0]        m_tdata,
    // Configuration writes.
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [SCALE_W-1:0]  cfg_data
);

    localparam int ODO_LSB = 4 * ADC_BITS;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_RUN   = 2'd1;
    localparam logic [1:0] T_MERGE = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [SCALE_W-1:0]  scale_reg  [NUM_CH];
    logic [OFFSET_W-1:0] offset_reg [NUM_CH];

    // Captured request.
    logic [NUM_CH-1:0][ADC_BITS-1:0] samp_reg;
    logic signed [31:0] odo_reg;
    logic               fwall_reg, clr_min_reg, clr_edge_reg;

    iwd_lane_res_t [NUM_CH-1:0] lanes;
    iwd_result_t                result;
    iwd_result_t                out_reg;
    logic                       out_valid_reg;

    logic accept, any_busy, update, out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == T_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign update   = (state_reg == T_MERGE) && out_free;

    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            any_busy = any_busy | lanes[i].busy;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_RUN;
                end
            end
            T_RUN:
            begin
                if (!any_busy)
                begin
                    state_next = T_MERGE;
                end
            end
            T_MERGE:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers; an index decodes to one scale or one offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                scale_reg[i]  <= SCALE_RST[i];
                offset_reg[i] <= OFFSET_RST[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE_FL:  scale_reg[0]  <= cfg_data;
                REG_SCALE_L:   scale_reg[1]  <= cfg_data;
                REG_SCALE_R:   scale_reg[2]  <= cfg_data;
                REG_SCALE_FR:  scale_reg[3]  <= cfg_data;
                REG_OFFSET_FL: offset_reg[0] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_L:  offset_reg[1] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_R:  offset_reg[2] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_FR: offset_reg[3] <= cfg_data[OFFSET_W-1:0];
                default:       scale_reg[0]  <= scale_reg[0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                samp_reg[i] <= s_tdata[i*ADC_BITS +: ADC_BITS];
            end
            odo_reg      <= $signed(s_tdata[ODO_LSB +: 32]);
            fwall_reg    <= s_tdata[ODO_LSB + 32];
            clr_min_reg  <= s_tdata[ODO_LSB + 33];
            clr_edge_reg <= s_tdata[ODO_LSB + 34];
        end
        if (update)
        begin
            out_reg <= result;
        end
    end

    // The lanes read the sample straight off the bus in the accepting cycle.
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        iwd_lane #(
            .ADC_BITS (ADC_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (accept),
            .sample (s_tdata[g*ADC_BITS +: ADC_BITS]),
            .scale  (scale_reg[g]),
            .offset ($signed(offset_reg[g])),
            .res    (lanes[g])
        );
    end

    iwd_merge #(
        .ADC_BITS (ADC_BITS)
    ) u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .update          (update),
        .lanes           (lanes),
        .samples         (samp_reg),
        .odometer        (odo_reg),
        .front_wall_mode (fwall_reg),
        .clear_min       (clr_min_reg),
        .clear_edge_pos  (clr_edge_reg),
        .result          (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.edge_right, out_reg.edge_left, out_reg.wall_mask,
                       out_reg.dev_fr, out_reg.dev_r, out_reg.dev_l, out_reg.dev_fl,
                       out_reg.dist_fr, out_reg.dist_r, out_reg.dist_l, out_reg.dist_fl};

    // The lanes are idle whenever a new request may be taken.
    `IWD_ASSERT_IMPLIES(a_idle_lanes, clk, rst_n, s_tready, !any_busy)
    // An accepted request blocks further requests until it is merged.
    `IWD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, accept, !s_tready)
    // The left and right distances never leave the clamp range.
    `IWD_ASSERT_IMPLIES(a_dist_range, clk, rst_n, m_tvalid,
                        out_reg.dist_l <= MAXD && out_reg.dist_r <= MAXD)
    // A left edge always resets the left minimum.
    `IWD_ASSERT_NEXT(a_edge_min, clk, rst_n, update && result.edge_left,
                     u_merge.min_l_reg == MAXD)

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// IR wall distance edge detector testbench
// Drives sample requests into the detector, predicts every result from its
// own model of the log-based distance estimate, the side minima and the wall
// edge logic, and checks each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import iwd_pkg::*;

    // One sensor tick as the sender sees it.
    typedef struct packed {
        logic                clr_edge;
        logic                clr_min;
        logic                fwall;
        logic signed [31:0]  odo;
        logic [3:0][11:0]    adc;   // front-left, left, right, front-right
    } ir_tick_t;

    localparam int  HOLD_OFF_CYCLES = 400;
    localparam int  WATCHDOG_LIMIT  = 5000;
    localparam int  SETTLE_CYCLES   = 80;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // From bit 0: adc_front_left, adc_left, adc_right, adc_front_right,
    // odometer, front_wall_mode, clear_min, clear_edge_pos, zero fill.
    logic [87:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // From bit 0: dist_front_left, dist_left, dist_right, dist_front_right,
    // dev_front_left, dev_left, dev_right, dev_front_right, wall_mask,
    // edge_left, edge_right, zero fill.
    logic [143:0]  m_tdata;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = REG_SCALE_FL;
    logic [SCALE_W-1:0] cfg_data = '0;

    ir_wall_distance_edge_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor state: calibration, previous samples, side minima and the
    // odometer positions of the last edges.
    // -----------------------------------------------------------------------
    int unsigned   cal_scale [4];
    longint        cal_offset [4];
    logic [11:0]   last_adc [4];
    longint        min_left, min_right;
    longint        edge_at_left, edge_at_right;

    ir_tick_t      pending_ticks [$];
    iwd_result_t   awaited_results [$];

    int            mismatches = 0;
    int            results_seen = 0;
    bit            no_idling = 1'b0;
    bit            stim_done = 1'b0;

    // Natural log in Q4.12, from log2 found by repeated squaring.
    function automatic longint unsigned ln_q12(int unsigned x);
        int                n;
        longint unsigned   mant;
        longint unsigned   lg;
        n = 0;
        while (n < 31 && (x >> (n + 1)) != 0)
            n++;
        mant = longint'(x) << (30 - n);
        lg   = n;
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 30;
            lg   = lg << 1;
            if (mant >= (64'd2 << 30))
            begin
                lg   = lg | 1;
                mant = mant >> 1;
            end
        end
        return (lg * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
    endfunction

    // Distance in Q8.8 mm; far is set when the unclamped value exceeds 135 mm.
    function automatic longint sensor_distance(int ch, logic [11:0] x, output bit far);
        longint unsigned lnv;
        longint          d;
        far = 1'b0;
        if (x <= MIN_ADC)
            return longint'(MAXD);
        lnv = ln_q12(x);
        if (lnv == 0)
            return longint'(MAXD);
        d = longint'((longint'(cal_scale[ch]) << 12) / lnv) - cal_offset[ch];
        if (d > longint'(MAXD))
        begin
            far = 1'b1;
            return longint'(MAXD);
        end
        return (d < 0) ? 0 : d;
    endfunction

    // Wall edge: a sharp rise over the running minimum after enough travel.
    function automatic bit wall_edge(longint d, inout longint minv, inout longint pos,
                                     input longint odo);
        if (3 * d - 5 * minv > longint'(MM_15) && odo - pos > longint'(EDGE_TRAVEL))
        begin
            pos  = odo;
            minv = longint'(MAXD);
            return 1'b1;
        end
        if (d < minv)
            minv = d;
        return 1'b0;
    endfunction

    function automatic longint side_deviation(longint d, logic [11:0] now, logic [11:0] old,
                                              longint fl, longint fr);
        int unsigned diff;
        diff = (now > old) ? now - old : old - now;
        if (d < longint'(MM_65) && diff < JITTER_CUT && fr > longint'(MM_30)
            && fl > longint'(MM_30))
            return d - longint'(MM_42);
        return 0;
    endfunction

    function automatic longint front_deviation(longint d, bit fwall);
        if (fwall)
            return (d < longint'(MM_60)) ? d - longint'(MM_42) : 0;
        return d - longint'(MM_130);
    endfunction

    // Works out the result of one tick and advances the predictor state.
    function automatic iwd_result_t forecast_result(ir_tick_t t);
        iwd_result_t r;
        longint      d [4];
        bit          far [4];
        longint      odo;
        odo = longint'(t.odo);
        if (t.clr_min)
        begin
            min_left  = longint'(MAXD);
            min_right = longint'(MAXD);
        end
        if (t.clr_edge)
        begin
            edge_at_left  = 0;
            edge_at_right = 0;
        end
        for (int i = 0; i < 4; i++)
            d[i] = sensor_distance(i, t.adc[i], far[i]);
        if (far[1])
            min_left = longint'(MAXD);
        if (far[2])
            min_right = longint'(MAXD);
        r.edge_right = wall_edge(d[2], min_right, edge_at_right, odo);
        r.edge_left  = wall_edge(d[1], min_left, edge_at_left, odo);
        r.dist_fl = DIST_W'(d[0]);
        r.dist_l  = DIST_W'(d[1]);
        r.dist_r  = DIST_W'(d[2]);
        r.dist_fr = DIST_W'(d[3]);
        r.dev_fl  = DEV_W'(front_deviation(d[0], t.fwall));
        r.dev_l   = DEV_W'(side_deviation(d[1], t.adc[1], last_adc[1], d[0], d[3]));
        r.dev_r   = DEV_W'(side_deviation(d[2], t.adc[2], last_adc[2], d[0], d[3]));
        r.dev_fr  = DEV_W'(front_deviation(d[3], t.fwall));
        r.wall_mask = {d[3] < longint'(MM_130), d[2] < longint'(MM_70),
                       d[1] < longint'(MM_70), d[0] < longint'(MM_130)};
        for (int i = 0; i < 4; i++)
            last_adc[i] = t.adc[i];
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then long.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idling || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // -----------------------------------------------------------------------
    // Driver: offers pending ticks, predicting each one as it is accepted.
    // -----------------------------------------------------------------------
    ir_tick_t offered;
    int       tx_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin : drive
            bit next_valid;
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(forecast_result(offered));
                next_valid = 1'b0;
            end
            // A request still waiting for ready keeps its valid and data.
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_ticks.size() > 0)
                begin
                    offered    = pending_ticks.pop_front();
                    s_tdata    <= {5'b0, offered};
                    next_valid = 1'b1;
                    tx_gap     = idle_gap();
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: random back-pressure plus one long hold-off, and the checks.
    // -----------------------------------------------------------------------
    int rx_gap = 0;
    int hold_off = 0;

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result %0d, %s expected %0d, got %0d",
                         $time, results_seen, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin : observe
            iwd_result_t want, got;
            bit          next_ready;
            if (m_tvalid && m_tready)
            begin
                got = iwd_result_t'(m_tdata[$bits(iwd_result_t)-1:0]);
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request outstanding", $time);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("dist_front_left", want.dist_fl, got.dist_fl);
                    check_field("dist_left", want.dist_l, got.dist_l);
                    check_field("dist_right", want.dist_r, got.dist_r);
                    check_field("dist_front_right", want.dist_fr, got.dist_fr);
                    check_field("dev_front_left", want.dev_fl, got.dev_fl);
                    check_field("dev_left", want.dev_l, got.dev_l);
                    check_field("dev_right", want.dev_r, got.dev_r);
                    check_field("dev_front_right", want.dev_fr, got.dev_fr);
                    check_field("wall_mask", want.wall_mask, got.wall_mask);
                    check_field("edge_left", want.edge_left, got.edge_left);
                    check_field("edge_right", want.edge_right, got.edge_right);
                end
                // Once, well into the run, stop taking results for a long
                // stretch so that the block backs up and stalls its input.
                if (results_seen == 300)
                    hold_off = HOLD_OFF_CYCLES;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                next_ready = 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                rx_gap     = idle_gap();
            end
            m_tready <= next_ready;
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done)
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------
    task automatic cfg_write(logic [2:0] idx, logic [SCALE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < REG_OFFSET_FL)
            cal_scale[idx] = value;
        else
            cal_offset[idx - REG_OFFSET_FL] = longint'(signed'(value[OFFSET_W-1:0]));
    endtask

    task automatic set_calibration(int unsigned s0, int unsigned s1, int unsigned s2,
                                   int unsigned s3, int o0, int o1, int o2, int o3);
        cfg_write(REG_SCALE_FL, SCALE_W'(s0));
        cfg_write(REG_SCALE_L, SCALE_W'(s1));
        cfg_write(REG_SCALE_R, SCALE_W'(s2));
        cfg_write(REG_SCALE_FR, SCALE_W'(s3));
        cfg_write(REG_OFFSET_FL, SCALE_W'(o0));
        cfg_write(REG_OFFSET_L, SCALE_W'(o1));
        cfg_write(REG_OFFSET_R, SCALE_W'(o2));
        cfg_write(REG_OFFSET_FR, SCALE_W'(o3));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Pause the sender until every result is back and the block has settled.
    // The queues and valid are looked at on the falling edge, once the driver
    // and monitor have finished their updates for the rising edge.
    task automatic drain();
        while (pending_ticks.size() > 0 || s_tvalid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_tick(int a0, int a1, int a2, int a3, int odo, bit fw, bit cm, bit ce);
        ir_tick_t t;
        t.adc[0] = 12'(a0);
        t.adc[1] = 12'(a1);
        t.adc[2] = 12'(a2);
        t.adc[3] = 12'(a3);
        t.odo = odo;
        t.fwall = fw;
        t.clr_min = cm;
        t.clr_edge = ce;
        pending_ticks.push_back(t);
    endtask

    // Mostly a robot driving along walls: the odometer creeps forward and the
    // samples wander, hold steady or drop out. The rest is plain noise.
    int walk_odo = 0;
    int walk_adc [4] = '{2000, 2000, 2000, 2000};

    task automatic add_random_ticks(int count);
        ir_tick_t t;
        int       roll;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                walk_odo += $urandom_range(0, 400);
                for (int i = 0; i < 4; i++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 35)
                        walk_adc[i] += $urandom_range(0, 4) - 2;
                    else if (roll < 55)
                        walk_adc[i] = $urandom_range(0, 60);
                    else if (roll < 70)
                        walk_adc[i] = $urandom_range(2500, 4095);
                    else
                        walk_adc[i] += $urandom_range(0, 800) - 400;
                    if (walk_adc[i] < 0)
                        walk_adc[i] = 0;
                    if (walk_adc[i] > 4095)
                        walk_adc[i] = 4095;
                    t.adc[i] = 12'(walk_adc[i]);
                end
                t.odo = walk_odo;
                t.fwall = $urandom_range(0, 1);
                t.clr_min = ($urandom_range(0, 19) == 0);
                t.clr_edge = ($urandom_range(0, 19) == 0);
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                    t.adc[i] = 12'($urandom);
                t.odo = $urandom;
                t.fwall = $urandom_range(0, 1);
                t.clr_min = $urandom_range(0, 1);
                t.clr_edge = $urandom_range(0, 1);
            end
            pending_ticks.push_back(t);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            cal_scale[i]  = SCALE_RST[i];
            cal_offset[i] = longint'(signed'(OFFSET_RST[i]));
            last_adc[i]   = '0;
        end
        min_left      = longint'(MAXD);
        min_right     = longint'(MAXD);
        edge_at_left  = 0;
        edge_at_right = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, with the calibration left at its reset values.
        add_tick(0, 0, 0, 0, 0, 0, 0, 0);
        add_tick(20, 20, 20, 20, 0, 1, 0, 0);               // low samples
        add_tick(21, 21, 21, 21, 10, 0, 0, 0);              // just above the cut
        add_tick(4095, 4095, 4095, 4095, 100, 1, 0, 0);
        add_tick(4095, 4094, 4093, 4095, 1000, 1, 0, 0);    // steady, but side gates stay shut
        add_tick(4094, 4095, 4095, 4094, 1100, 0, 1, 0);    // clear minima
        add_tick(4000, 4095, 4095, 4000, 1200, 0, 0, 0);
        add_tick(4000, 10, 10, 4000, 2000, 0, 0, 0);        // edge on both sides
        add_tick(4000, 4095, 4095, 4000, 2100, 0, 0, 0);
        add_tick(4000, 10, 10, 4000, 2200, 0, 0, 0);        // too little travel
        add_tick(4095, 4095, 4095, 4095, 32'h7fffffff, 1, 0, 0);
        add_tick(4095, 15, 15, 4095, 32'h80000000, 1, 0, 0); // odometer far negative
        add_tick(4095, 4095, 4095, 4095, -5000, 0, 0, 1);   // clear edge positions
        add_tick(4095, 5, 5, 4095, -4000, 0, 0, 0);
        add_tick(4095, 30, 35, 4095, 50000, 0, 0, 0);       // far side readings
        add_tick(2000, 300, 100, 300, 50100, 1, 0, 0);
        add_tick(300, 2000, 2000, 2000, 50200, 1, 1, 1);
        add_tick(50, 2001, 2002, 50, 50300, 0, 0, 0);
        add_tick(4095, 3000, 3001, 1024, 50400, 1, 0, 0);
        add_tick(2048, 2048, 2048, 2048, 32'h55555555, 0, 1, 0);
        add_tick(1365, 2730, 1365, 2730, 32'haaaaaaaa, 1, 0, 1);
        drain();

        // Calibration near the defaults.
        set_calibration(271360 + $urandom_range(0, 20000), 218035 - $urandom_range(0, 20000),
                        247117, 319565 + $urandom_range(0, 20000),
                        26598, 21862 + $urandom_range(0, 3000), 25421 - 3000, 32333);
        add_random_ticks(130);
        drain();

        // Largest numerators and most negative offsets: mostly far readings.
        set_calibration(1048575, 1048575, 1048575, 1048575,
                        -131072, -131072, -131072, -131072);
        add_random_ticks(80);
        drain();

        // Zero numerators and largest offsets: every distance above the sample cut goes negative.
        set_calibration(0, 0, 0, 0, 131071, 131071, 131071, 131071);
        add_random_ticks(50);
        drain();

        // Anything goes, and no idling on either side.
        no_idling = 1'b1;
        set_calibration($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                        $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                        $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
                        $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072);
        add_random_ticks(90);
        drain();
        no_idling = 1'b0;

        // Back to the reset calibration for the long closing stretch.
        set_calibration(SCALE_RST[0], SCALE_RST[1], SCALE_RST[2], SCALE_RST[3],
                        signed'(OFFSET_RST[0]), signed'(OFFSET_RST[1]),
                        signed'(OFFSET_RST[2]), signed'(OFFSET_RST[3]));
        add_random_ticks(180);
        while (pending_ticks.size() > 0 || s_tvalid || awaited_results.size() > 0)
            @(negedge clk);
        stim_done = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
